@@ rtl/core/ppsa_pkg.sv @@
// ----------------------------------------------------------------------------
// ppsa_pkg: shared types and constants
// Task table depth, phase codes and inter-module control structs.
// ----------------------------------------------------------------------------
package ppsa_pkg;

    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        PHASE_NEW   = 2'd0,
        PHASE_READY = 2'd1,
        PHASE_RUN   = 2'd2,
        PHASE_OVER  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0]  id;
        phase_t      phase;
        logic [7:0]  base;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [15:0] done;
        logic [15:0] waited;
    } entry_t;

    // Per-cell command for one step of a tick.
    typedef struct packed {
        logic        load;     // write loaded entry into this cell
        logic        arrive;   // arrival and aging pass
        logic        mark_run; // set phase run, bump done
        logic        mark_rdy; // set phase ready
        logic        mark_fin; // set phase over, store wait
        logic [15:0] fin_wait;
        logic [15:0] now;
    } cell_cmd_t;

endpackage

@@ rtl/core/preemptive_priority_scheduler_aging.sv @@
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_aging: priority scheduler with aging
// Task table as a ring of cells; each tick applies arrival and aging, scans
// the ring for winner and running task, then applies the phase changes.
// ----------------------------------------------------------------------------
// channel  dir  tdata fields (low bit up)                         tuser
// s_       in   task_id, base_priority, arrival_tick, burst_length kind
// m_       out  running_id, cpu_idle, finished_valid, finished_id,
//               finished_turnaround, finished_wait, all_done        -
// A load is written into the next free cell as it is accepted. A tick passes
// through an arrival/aging state, one full ring rotation to scan (one entry
// a cycle past cell 0), an update state and a result state. The next item
// is taken only once the block is idle again with no result pending.
// Reset clears count, tick and control.
// A stalled result holds; the next item waits until it is taken.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_aging
    import ppsa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // task_id, base_priority, arrival_tick, burst_length
    input  logic        s_tuser,  // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata   // running_id, cpu_idle, finished_valid, finished_id,
                                  // finished_turnaround, finished_wait, all_done, pad
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_AGE  = 5'b00010,
        ST_SCAN = 5'b00100,
        ST_UPD  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [15:0] now_reg, now_next;
    logic        win_v_reg, win_v_next, run_v_reg, run_v_next;
    logic [IDX_W-1:0] win_reg, win_next, run_reg, run_next;
    logic [16:0] best_reg, best_next;
    entry_t      win_e_reg, win_e_next, run_e_reg, run_e_next;
    logic        mv_reg, mv_next;
    logic [55:0] md_reg, md_next;

    entry_t    ring [MAX_TASKS];
    entry_t    feed [MAX_TASKS];
    cell_cmd_t cmd  [MAX_TASKS];
    logic      rotate;
    entry_t    ld;

    assign ld.id      = s_tdata[7:0];
    assign ld.base    = s_tdata[15:8];
    assign ld.arrival = s_tdata[31:16];
    assign ld.burst   = s_tdata[47:32];
    assign ld.phase   = PHASE_NEW;
    assign ld.done    = 16'd0;
    assign ld.waited  = 16'd0;

    assign rotate = (state_reg == ST_SCAN);
    assign s_tready = (state_reg == ST_IDLE) && !mv_reg;

    // update decisions
    logic        do_fin, do_pre, do_cont, do_start;
    logic [15:0] ta, wt;
    always_comb begin
        do_fin = 1'b0; do_pre = 1'b0; do_cont = 1'b0; do_start = 1'b0;
        ta = (now_reg >= run_e_reg.arrival) ? now_reg - run_e_reg.arrival : 16'd0;
        wt = (ta >= run_e_reg.burst) ? ta - run_e_reg.burst : 16'd0;
        if (run_v_reg) begin
            if (run_e_reg.done >= run_e_reg.burst) do_fin = 1'b1;
            else if (win_v_reg && best_reg > ({1'b0, run_e_reg.waited} + 17'(run_e_reg.base)))
                do_pre = 1'b1;
            else do_cont = 1'b1;
        end
        if (!do_pre && !do_cont && win_v_reg && win_e_reg.done < win_e_reg.burst)
            do_start = 1'b1;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_TASKS; g++) begin : g_cell
            logic [IDX_W-1:0] idx;
            assign idx = IDX_W'(g);
            always_comb begin
                cmd[g] = '0;
                cmd[g].now = now_reg;
                cmd[g].fin_wait = wt;
                cmd[g].load = (state_reg == ST_IDLE) && s_tvalid && s_tready && !s_tuser
                              && count_reg == CNT_W'(g);
                cmd[g].arrive = (state_reg == ST_AGE) && CNT_W'(g) < count_reg;
                if (state_reg == ST_UPD) begin
                    cmd[g].mark_fin = do_fin && run_reg == idx;
                    cmd[g].mark_rdy = do_pre && run_reg == idx;
                    cmd[g].mark_run = ((do_pre || do_start) && win_reg == idx)
                                      || (do_cont && run_reg == idx);
                end
            end
            if (g == MAX_TASKS - 1) begin : g_wrap
                assign feed[g] = rotate ? ring[0] : ld;
            end else begin : g_link
                assign feed[g] = rotate ? ring[g+1] : ld;
            end
            ppsa_cell u_cell (
                .aclk(aclk), .rotate(rotate), .entry_in(feed[g]),
                .cmd(cmd[g]), .entry_out(ring[g])
            );
        end
    endgenerate

    logic [16:0] aged0;
    logic        in_tab;
    assign aged0  = {1'b0, ring[0].waited} + 17'(ring[0].base);
    assign in_tab = {1'b0, pos_reg} < count_reg;

    // all-done from the ring after the update has landed
    logic all_c;
    always_comb begin
        all_c = 1'b1;
        for (int k = 0; k < MAX_TASKS; k++)
            if (CNT_W'(k) < count_reg && ring[k].phase != PHASE_OVER) all_c = 1'b0;
    end

    always_comb begin
        state_next = state_reg; count_next = count_reg; pos_next = pos_reg;
        now_next = now_reg; win_v_next = win_v_reg; run_v_next = run_v_reg;
        win_next = win_reg; run_next = run_reg; best_next = best_reg;
        win_e_next = win_e_reg; run_e_next = run_e_reg;
        mv_next = mv_reg; md_next = md_reg;
        if (mv_reg && m_tready) mv_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    if (s_tuser) state_next = ST_AGE;
                    else if (count_reg < CNT_W'(MAX_TASKS)) count_next = count_reg + 1'b1;
                end
            end
            ST_AGE: begin
                win_v_next = 1'b0; run_v_next = 1'b0; best_next = '0;
                pos_next = '0; state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (in_tab) begin
                    if (ring[0].phase == PHASE_READY && (!win_v_reg || aged0 >= best_reg)) begin
                        win_v_next = 1'b1; win_next = pos_reg;
                        best_next = aged0; win_e_next = ring[0];
                    end
                    if (ring[0].phase == PHASE_RUN && !run_v_reg) begin
                        run_v_next = 1'b1; run_next = pos_reg; run_e_next = ring[0];
                    end
                end
                pos_next = pos_reg + 1'b1;
                if (pos_reg == IDX_W'(MAX_TASKS - 1)) state_next = ST_UPD;
            end
            ST_UPD: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!mv_reg) begin
                    mv_next = 1'b1;
                    md_next = '0;
                    md_next[7:0]   = (do_pre || do_start) ? win_e_reg.id :
                                     do_cont ? run_e_reg.id : 8'd0;
                    md_next[8]     = !(do_pre || do_start || do_cont);
                    md_next[9]     = do_fin;
                    md_next[17:10] = do_fin ? run_e_reg.id : 8'd0;
                    md_next[33:18] = do_fin ? ta : 16'd0;
                    md_next[49:34] = do_fin ? wt : 16'd0;
                    md_next[50]    = all_c;
                    if (now_reg != CNT_MAX) now_next = now_reg + 16'd1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE; count_reg <= '0; now_reg <= '0; mv_reg <= 1'b0;
            pos_reg <= '0; win_v_reg <= 1'b0; run_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next; count_reg <= count_next; now_reg <= now_next;
            mv_reg <= mv_next; pos_reg <= pos_next; win_v_reg <= win_v_next;
            run_v_reg <= run_v_next;
        end
        win_reg <= win_next; run_reg <= run_next; best_reg <= best_next;
        win_e_reg <= win_e_next; run_e_reg <= run_e_next; md_reg <= md_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

endmodule

@@ rtl/core/ppsa_cell.sv @@
// ----------------------------------------------------------------------------
// ppsa_cell: one task table entry
// Holds one entry, takes a loaded entry, applies arrival, aging and phase updates,
// and passes its entry to the previous cell (cell 0 to the last) when the chain rotates.
// ----------------------------------------------------------------------------
module ppsa_cell
    import ppsa_pkg::*;
(
    input  logic      aclk,
    input  logic      rotate,
    input  entry_t    entry_in,
    input  cell_cmd_t cmd,
    output entry_t    entry_out
);

    entry_t entry_reg, entry_next;

    always_comb begin
        entry_next = entry_reg;
        if (rotate) begin
            entry_next = entry_in;
        end else if (cmd.load) begin
            entry_next = entry_in;
        end else if (cmd.arrive) begin
            if (entry_reg.phase == PHASE_NEW && entry_reg.arrival == cmd.now) begin
                entry_next.phase = PHASE_READY;
            end else if (entry_reg.phase == PHASE_READY && entry_reg.arrival < cmd.now
                         && entry_reg.waited != CNT_MAX) begin
                entry_next.waited = entry_reg.waited + 16'd1;
            end
        end else if (cmd.mark_fin) begin
            entry_next.phase  = PHASE_OVER;
            entry_next.waited = cmd.fin_wait;
        end else if (cmd.mark_run) begin
            entry_next.phase = PHASE_RUN;
            if (entry_reg.done != CNT_MAX) entry_next.done = entry_reg.done + 16'd1;
        end else if (cmd.mark_rdy) begin
            entry_next.phase = PHASE_READY;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_out = entry_reg;

endmodule

@@ rtl/core/ppsa_checker.sv @@
// ----------------------------------------------------------------------------
// ppsa_checker: port-level checks
// Handshake and result consistency seen at the top level ports.
// ----------------------------------------------------------------------------
module ppsa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");

    a_idle_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> m_tdata[7:0] == 8'd0) else $error("idle with id");

    a_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[9] |-> m_tdata[49:10] == 40'd0) else $error("stray finish");

    a_nobusy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("took item with result pending");

endmodule

bind preemptive_priority_scheduler_aging ppsa_checker u_ppsa_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
